/* rtl/cfr_pkg.sv */
package cfr_pkg;

  localparam logic [30:0] Q30_ONE = 31'h4000_0000;
  localparam logic [15:0] Q15_ONE = 16'h8000;

  localparam int SQ1_IN_W = 60;
  localparam int SQ2_IN_W = 50;
  localparam int DIV_W    = 32;
  localparam int FRAC_W   = 16;

  typedef struct packed {
    logic        zero;
    logic        neg;
    logic [28:0] tmag;
    logic [27:0] oc2;
    logic [30:0] c2;
    logic [30:0] s2;
    logic [27:0] os2;
    logic [15:0] c;
    logic [15:0] o;
  } sq1_sb_t;

  typedef struct packed {
    logic        zero;
    logic [29:0] big_a;
    logic [30:0] t1;
    logic [30:0] c2;
    logic [30:0] s2;
    logic [27:0] os2;
    logic [15:0] c;
    logic [15:0] o;
  } sq2_sb_t;

endpackage

/* rtl/cfr_sqrt.sv */
module cfr_sqrt #(
  parameter int IN_W = 60,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   in_v,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_vld,
  output logic [IN_W/2-1:0] out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int RW = IN_W / 2;

  logic [RW:0]     rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [IN_W-1:0] v_r    [RW];
  logic [SB_W-1:0] sb_r   [RW];
  logic [RW-1:0]   vld_r;

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [RW:0]     rem_p;
    logic [RW-1:0]   root_p;
    logic [IN_W-1:0] v_p;
    logic [SB_W-1:0] sb_p;
    logic            vld_p;
    logic [RW+2:0]   work;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   diff;
    logic            ge;

    if (g == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign v_p    = in_v;
      assign sb_p   = in_sb;
      assign vld_p  = in_vld;
    end else begin : g_next
      assign rem_p  = rem_r[g-1];
      assign root_p = root_r[g-1];
      assign v_p    = v_r[g-1];
      assign sb_p   = sb_r[g-1];
      assign vld_p  = vld_r[g-1];
    end

    assign work  = {rem_p, v_p[IN_W-1 -: 2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign diff  = work - trial;
    assign ge    = (work >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g]  <= ge ? diff[RW:0] : work[RW:0];
      root_r[g] <= {root_p[RW-2:0], ge};
      v_r[g]    <= {v_p[IN_W-3:0], 2'b00};
      sb_r[g]   <= sb_p;
    end
  end

  assign out_vld  = vld_r[RW-1];
  assign out_root = root_r[RW-1];
  assign out_sb   = sb_r[RW-1];

endmodule

/* rtl/cfr_ratio.sv */
module cfr_ratio #(
  parameter int DW   = 32,
  parameter int FB   = 16,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  logic [DW-1:0]   in_pos,
  input  logic [DW-1:0]   in_neg,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_vld,
  output logic [FB:0]     out_q,
  output logic [SB_W-1:0] out_sb
);

  localparam int DENW = DW + 1;
  localparam int QW   = FB + 1;
  localparam int DSW  = DENW + FB;
  localparam logic [QW-1:0] ONE = {1'b1, {FB{1'b0}}};

  logic [DENW-1:0] num_w;
  logic [DENW-1:0] den_w;
  logic [DSW-1:0]  dfull_w;

  assign num_w   = (in_pos > in_neg) ? {1'b0, in_pos - in_neg} : '0;
  assign den_w   = {1'b0, in_pos} + {1'b0, in_neg};
  assign dfull_w = {num_w, {FB{1'b0}}} + {{(FB+1){1'b0}}, den_w[DENW-1:1]};

  logic            vld0_r;
  logic            dz0_r;
  logic [DENW-1:0] den0_r;
  logic [DENW-1:0] rem0_r;
  logic [QW-1:0]   low0_r;
  logic [SB_W-1:0] sb0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    dz0_r  <= (den_w == '0);
    den0_r <= den_w;
    rem0_r <= {1'b0, dfull_w[DSW-1:QW]};
    low0_r <= dfull_w[QW-1:0];
    sb0_r  <= in_sb;
  end

  logic [DENW-1:0] rem_r [QW];
  logic [DENW-1:0] den_r [QW];
  logic [QW-1:0]   q_r   [QW];
  logic [QW-1:0]   low_r [QW];
  logic [SB_W-1:0] sb_r  [QW];
  logic [QW-1:0]   dz_r;
  logic [QW-1:0]   vld_r;

  for (genvar g = 0; g < QW; g++) begin : g_stage
    logic [DENW-1:0] rem_p;
    logic [DENW-1:0] den_p;
    logic [QW-1:0]   q_p;
    logic [QW-1:0]   low_p;
    logic [SB_W-1:0] sb_p;
    logic            dz_p;
    logic            vld_p;
    logic [DENW:0]   work;
    logic [DENW:0]   denx;
    logic [DENW:0]   diff;
    logic            ge;

    if (g == 0) begin : g_first
      assign rem_p = rem0_r;
      assign den_p = den0_r;
      assign q_p   = '0;
      assign low_p = low0_r;
      assign sb_p  = sb0_r;
      assign dz_p  = dz0_r;
      assign vld_p = vld0_r;
    end else begin : g_next
      assign rem_p = rem_r[g-1];
      assign den_p = den_r[g-1];
      assign q_p   = q_r[g-1];
      assign low_p = low_r[g-1];
      assign sb_p  = sb_r[g-1];
      assign dz_p  = dz_r[g-1];
      assign vld_p = vld_r[g-1];
    end

    assign work = {rem_p, low_p[QW-1]};
    assign denx = {1'b0, den_p};
    assign diff = work - denx;
    assign ge   = (work >= denx);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else begin
        vld_r[g] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g] <= ge ? diff[DENW-1:0] : work[DENW-1:0];
      den_r[g] <= den_p;
      q_r[g]   <= {q_p[QW-2:0], ge};
      low_r[g] <= {low_p[QW-2:0], 1'b0};
      sb_r[g]  <= sb_p;
      dz_r[g]  <= dz_p;
    end
  end

  assign out_vld = vld_r[QW-1];
  assign out_sb  = sb_r[QW-1];
  assign out_q   = (dz_r[QW-1] || (q_r[QW-1] > ONE)) ? ONE : q_r[QW-1];

endmodule

/* rtl/conductor_fresnel_reflectance_unit.sv */
// Channel  Handshake            Ports
// input    start, busy          in_cos_incident, in_index_outside, in_index_inside, in_absorption
// result   out_valid (strobe)   out_reflectance
//
// One request is taken in every cycle; busy stays low.
// Each request runs to its result through the two square roots and the two
// dividers, which retire one result bit per stage.
// Reset is synchronous and clears only the valid bits of the stages.
// The receiver cannot stall, so the pipeline never holds.
module conductor_fresnel_reflectance_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [16:0] in_cos_incident,
  input  logic [15:0]        in_index_outside,
  input  logic [15:0]        in_index_inside,
  input  logic [15:0]        in_absorption,
  output logic               out_valid,
  output logic [15:0]        out_reflectance
);

  localparam int SQ1_SB_W = $bits(cfr_pkg::sq1_sb_t);
  localparam int SQ2_SB_W = $bits(cfr_pkg::sq2_sb_t);
  localparam int LAT = 4 + cfr_pkg::SQ1_IN_W / 2 + 1 + cfr_pkg::SQ2_IN_W / 2 + 3
                     + cfr_pkg::FRAC_W + 2 + 2;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Stage 1: clamp the cosine and form the squares.
  logic        pos_w;
  logic [15:0] csat_w;
  logic [31:0] csq_w;
  logic [31:0] nsq_w;
  logic [31:0] ksq_w;
  logic [31:0] osq_w;

  assign pos_w  = !in_cos_incident[16] && (in_cos_incident != 17'sd0);
  assign csat_w = (in_cos_incident[15:0] > cfr_pkg::Q15_ONE) ? cfr_pkg::Q15_ONE
                                                              : in_cos_incident[15:0];
  assign csq_w  = csat_w * csat_w;
  assign nsq_w  = in_index_inside * in_index_inside;
  assign ksq_w  = in_absorption * in_absorption;
  assign osq_w  = in_index_outside * in_index_outside;

  logic        v1_r;
  logic        z1_r;
  logic [15:0] c1_r;
  logic [30:0] c21_r;
  logic [15:0] o1_r;
  logic [27:0] e1_r;
  logic [27:0] k1_r;
  logic [27:0] oo1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    z1_r  <= !pos_w;
    c1_r  <= csat_w;
    c21_r <= csq_w[30:0];
    o1_r  <= in_index_outside;
    e1_r  <= nsq_w[31:4];
    k1_r  <= ksq_w[31:4];
    oo1_r <= osq_w[31:4];
  end

  // Stage 2: sine squared and the outside index scaled by both.
  logic [30:0] s2c_w;
  logic [58:0] os_prod_w;
  logic [58:0] oc_prod_w;

  assign s2c_w     = cfr_pkg::Q30_ONE - c21_r;
  assign os_prod_w = oo1_r * s2c_w;
  assign oc_prod_w = oo1_r * c21_r;

  logic        v2_r;
  logic        z2_r;
  logic [15:0] c2c_r;
  logic [30:0] c22_r;
  logic [30:0] s22_r;
  logic [27:0] os22_r;
  logic [27:0] oc22_r;
  logic [27:0] e2_r;
  logic [27:0] k2_r;
  logic [15:0] o2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    z2_r   <= z1_r;
    c2c_r  <= c1_r;
    c22_r  <= c21_r;
    s22_r  <= s2c_w;
    os22_r <= os_prod_w[57:30];
    oc22_r <= oc_prod_w[57:30];
    e2_r   <= e1_r;
    k2_r   <= k1_r;
    o2_r   <= o1_r;
  end

  // Stage 3: signed term and its magnitude, product of the squares.
  logic signed [29:0] t0_w;
  logic [29:0]        t0u_w;
  logic [29:0]        tmag_w;
  logic [55:0]        ek_w;

  assign t0_w   = $signed({2'b00, e2_r}) - $signed({2'b00, k2_r})
                - $signed({2'b00, os22_r});
  assign t0u_w  = t0_w;
  assign tmag_w = t0u_w[29] ? (30'd0 - t0u_w) : t0u_w;
  assign ek_w   = e2_r * k2_r;

  logic            v3_r;
  logic [55:0]     ek3_r;
  cfr_pkg::sq1_sb_t sb3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    ek3_r      <= ek_w;
    sb3_r.zero <= z2_r;
    sb3_r.neg  <= t0u_w[29];
    sb3_r.tmag <= tmag_w[28:0];
    sb3_r.oc2  <= oc22_r;
    sb3_r.c2   <= c22_r;
    sb3_r.s2   <= s22_r;
    sb3_r.os2  <= os22_r;
    sb3_r.c    <= c2c_r;
    sb3_r.o    <= o2_r;
  end

  // Stage 4: radicand of the first square root.
  logic [57:0] tsq_w;
  logic [58:0] m_w;

  assign tsq_w = sb3_r.tmag * sb3_r.tmag;
  assign m_w   = {1'b0, tsq_w} + {1'b0, ek3_r, 2'b00};

  logic             v4_r;
  logic [58:0]      m4_r;
  cfr_pkg::sq1_sb_t sb4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    m4_r  <= m_w;
    sb4_r <= sb3_r;
  end

  logic                                sq1_vld;
  logic [cfr_pkg::SQ1_IN_W/2-1:0]      sq1_root;
  logic [SQ1_SB_W-1:0]                 sq1_sbv;
  cfr_pkg::sq1_sb_t                    sq1_sb;

  cfr_sqrt #(
    .IN_W (cfr_pkg::SQ1_IN_W),
    .SB_W (SQ1_SB_W)
  ) u_sqrt_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v4_r),
    .in_v     ({1'b0, m4_r}),
    .in_sb    (sb4_r),
    .out_vld  (sq1_vld),
    .out_root (sq1_root),
    .out_sb   (sq1_sbv)
  );

  assign sq1_sb = cfr_pkg::sq1_sb_t'(sq1_sbv);

  // Stage 5: radicand of the second square root and the s-polarized sum.
  logic [30:0] h_w;
  logic [30:0] t1_w;

  assign h_w  = sq1_sb.neg ? ({1'b0, sq1_root} - {2'b00, sq1_sb.tmag})
                           : ({1'b0, sq1_root} + {2'b00, sq1_sb.tmag});
  assign t1_w = {1'b0, sq1_root} + {3'b000, sq1_sb.oc2};

  logic             v5_r;
  logic [30:0]      h5_r;
  cfr_pkg::sq2_sb_t sb5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= sq1_vld;
    end
  end

  always_ff @(posedge clk) begin
    h5_r        <= h_w;
    sb5_r.zero  <= sq1_sb.zero;
    sb5_r.big_a <= sq1_root;
    sb5_r.t1    <= t1_w;
    sb5_r.c2    <= sq1_sb.c2;
    sb5_r.s2    <= sq1_sb.s2;
    sb5_r.os2   <= sq1_sb.os2;
    sb5_r.c     <= sq1_sb.c;
    sb5_r.o     <= sq1_sb.o;
  end

  logic                           sq2_vld;
  logic [cfr_pkg::SQ2_IN_W/2-1:0] sq2_root;
  logic [SQ2_SB_W-1:0]            sq2_sbv;
  cfr_pkg::sq2_sb_t               sq2_sb;

  cfr_sqrt #(
    .IN_W (cfr_pkg::SQ2_IN_W),
    .SB_W (SQ2_SB_W)
  ) u_sqrt_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v5_r),
    .in_v     ({h5_r, 19'd0}),
    .in_sb    (sb5_r),
    .out_vld  (sq2_vld),
    .out_root (sq2_root),
    .out_sb   (sq2_sbv)
  );

  assign sq2_sb = cfr_pkg::sq2_sb_t'(sq2_sbv);

  // Stage 6: partial products of the p-polarized terms.
  logic [31:0] co_w;
  logic [60:0] p1_prod_w;
  logic [58:0] p2_prod_w;

  assign co_w      = sq2_sb.c * sq2_sb.o;
  assign p1_prod_w = sq2_sb.c2 * sq2_sb.big_a;
  assign p2_prod_w = sq2_sb.os2 * sq2_sb.s2;

  logic        v6_r;
  logic        z6_r;
  logic [31:0] co6_r;
  logic [24:0] a6_r;
  logic [30:0] p16_r;
  logic [28:0] p26_r;
  logic [30:0] t16_r;
  logic [30:0] s26_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= sq2_vld;
    end
  end

  always_ff @(posedge clk) begin
    z6_r  <= sq2_sb.zero;
    co6_r <= co_w;
    a6_r  <= sq2_root;
    p16_r <= p1_prod_w[60:30];
    p26_r <= p2_prod_w[58:30];
    t16_r <= sq2_sb.t1;
    s26_r <= sq2_sb.s2;
  end

  // Stage 7: cross term and p-polarized sum.
  logic [56:0] t2_prod_w;

  assign t2_prod_w = co6_r * a6_r;

  logic        v7_r;
  logic        z7_r;
  logic [30:0] t17_r;
  logic [30:0] t27_r;
  logic [31:0] t37_r;
  logic [30:0] s27_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else begin
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    z7_r  <= z6_r;
    t17_r <= t16_r;
    t27_r <= t2_prod_w[56:26];
    t37_r <= {1'b0, p16_r} + {3'b000, p26_r};
    s27_r <= s26_r;
  end

  // Stage 8: cross term of the p-polarized ratio.
  logic [61:0] t4_prod_w;

  assign t4_prod_w = t27_r * s27_r;

  logic        v8_r;
  logic        z8_r;
  logic [30:0] t18_r;
  logic [30:0] t28_r;
  logic [31:0] t38_r;
  logic [31:0] t48_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v8_r <= 1'b0;
    end else begin
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    z8_r  <= z7_r;
    t18_r <= t17_r;
    t28_r <= t27_r;
    t38_r <= t37_r;
    t48_r <= t4_prod_w[61:30];
  end

  logic                    rs_vld;
  logic [cfr_pkg::FRAC_W:0] rs_q;
  logic                    rs_z;
  logic                    pp_vld;
  logic [cfr_pkg::FRAC_W:0] pp_q;
  logic                    pp_z;

  cfr_ratio #(
    .DW   (cfr_pkg::DIV_W),
    .FB   (cfr_pkg::FRAC_W),
    .SB_W (1)
  ) u_ratio_s (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v8_r),
    .in_pos  ({1'b0, t18_r}),
    .in_neg  ({1'b0, t28_r}),
    .in_sb   (z8_r),
    .out_vld (rs_vld),
    .out_q   (rs_q),
    .out_sb  (rs_z)
  );

  cfr_ratio #(
    .DW   (cfr_pkg::DIV_W),
    .FB   (cfr_pkg::FRAC_W),
    .SB_W (1)
  ) u_ratio_p (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (v8_r),
    .in_pos  (t38_r),
    .in_neg  (t48_r),
    .in_sb   (z8_r),
    .out_vld (pp_vld),
    .out_q   (pp_q),
    .out_sb  (pp_z)
  );

  // Stage 9: p-polarized reflectance.
  logic [33:0] rp_prod_w;

  assign rp_prod_w = rs_q * pp_q;

  logic        v9_r;
  logic        z9_r;
  logic [16:0] rs9_r;
  logic [16:0] rp9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v9_r <= 1'b0;
    end else begin
      v9_r <= rs_vld && pp_vld;
    end
  end

  always_ff @(posedge clk) begin
    z9_r  <= rs_z || pp_z;
    rs9_r <= rs_q;
    rp9_r <= rp_prod_w[32:16];
  end

  // Stage 10: mean of both reflectances.
  logic [18:0] sum_w;
  logic [16:0] mean_w;
  logic [15:0] out_reflectance_nxt;

  assign sum_w  = {2'b00, rs9_r} + {2'b00, rp9_r} + 19'd2;
  assign mean_w = sum_w[18:2];

  always_comb begin
    if (z9_r) begin
      out_reflectance_nxt = 16'd0;
    end else if (mean_w > {1'b0, cfr_pkg::Q15_ONE}) begin
      out_reflectance_nxt = cfr_pkg::Q15_ONE;
    end else begin
      out_reflectance_nxt = mean_w[15:0];
    end
  end

  logic        out_valid_r;
  logic [15:0] out_reflectance_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    out_reflectance_r <= out_reflectance_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_reflectance = out_reflectance_r;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("request did not produce a result after the pipeline latency");

  a_backside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cos_incident[16] || (in_cos_incident == 17'sd0)))
      |-> ##LAT (out_reflectance == 16'd0))
    else $error("nonpositive cosine gave a nonzero reflectance");

  a_ratios_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    rs_vld == pp_vld)
    else $error("the two ratio pipelines lost alignment");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_reflectance <= cfr_pkg::Q15_ONE))
    else $error("reflectance above one");
`endif

endmodule

/* verif/cfr_checker.sv */
`timescale 1ns / 100ps

module cfr_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [16:0] in_cos_incident,
  input  logic [15:0]        in_index_outside,
  input  logic [15:0]        in_index_inside,
  input  logic [15:0]        in_absorption,
  input  logic               out_valid,
  input  logic [15:0]        out_reflectance,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  logic [15:0] expected_reflectance_q[$];

  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] fresnel_ratio(input logic [63:0] pos, input logic [63:0] neg);
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    num = (pos > neg) ? pos - neg : 64'd0;
    den = pos + neg;
    if (den == 0) return 64'd65536;
    q = ((num << 16) + (den >> 1)) / den;
    return (q > 64'd65536) ? 64'd65536 : q;
  endfunction

  function automatic logic [15:0] predict_reflectance(input logic [16:0] raw_c,
                                                      input logic [15:0] o_in,
                                                      input logic [15:0] n_in,
                                                      input logic [15:0] k_in);
    logic [63:0] c, c2, s2, e, kk, oo, os2, oc2, tmag, m, big_a, h, a;
    logic [63:0] o, t1, t2, t3, t4, rs, p, rp, r;
    logic signed [63:0] t0;
    if (raw_c[16] || raw_c == 0) return 16'd0;
    c = (raw_c > 17'd32768) ? 64'd32768 : 64'(raw_c);
    o = 64'(o_in);
    c2 = c * c;
    s2 = 64'd1073741824 - c2;
    e = (64'(n_in) * 64'(n_in)) >> 4;
    kk = (64'(k_in) * 64'(k_in)) >> 4;
    oo = (o * o) >> 4;
    os2 = (oo * s2) >> 30;
    oc2 = (oo * c2) >> 30;
    t0 = $signed(e) - $signed(kk) - $signed(os2);
    tmag = (t0 < 0) ? 64'(-t0) : 64'(t0);
    m = tmag * tmag + 64'd4 * e * kk;
    big_a = isqrt(m);
    h = (t0 < 0) ? big_a - tmag : big_a + tmag;
    a = isqrt(h << 19);
    t1 = big_a + oc2;
    t2 = ((c * o) * a) >> 26;
    rs = fresnel_ratio(t1, t2);
    t3 = ((c2 * big_a) >> 30) + ((os2 * s2) >> 30);
    t4 = (t2 * s2) >> 30;
    p = fresnel_ratio(t3, t4);
    rp = (rs * p) >> 16;
    r = (rs + rp + 2) >> 2;
    if (r > 64'd32768) r = 64'd32768;
    return r[15:0];
  endfunction

  assign pending_count = expected_reflectance_q.size();

  initial begin
    fail_count = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      expected_reflectance_q.insert(expected_reflectance_q.size(),
                                    predict_reflectance(in_cos_incident, in_index_outside,
                                                        in_index_inside, in_absorption));
    end
    if (rst_n && out_valid) begin
      result_count <= result_count + 1;
      if (expected_reflectance_q.size() == 0) begin
        $display("%0t: unexpected result reflectance=%0d", $time, out_reflectance);
        fail_count <= fail_count + 1;
      end else if (expected_reflectance_q[0] !== out_reflectance) begin
        $display("%0t: reflectance mismatch expected=%0d actual=%0d", $time,
                 expected_reflectance_q[0], out_reflectance);
        fail_count <= fail_count + 1;
        void'(expected_reflectance_q.pop_front());
      end else begin
        void'(expected_reflectance_q.pop_front());
      end
    end
  end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  localparam int LATENCY = 83;
  localparam int CYCLE_LIMIT = 40000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [16:0] in_cos_incident;
  logic [15:0]        in_index_outside;
  logic [15:0]        in_index_inside;
  logic [15:0]        in_absorption;
  logic               out_valid;
  logic [15:0]        out_reflectance;
  int                 fail_count;
  int                 pending_count;
  int                 result_count;
  int                 cycle_count;
  int                 request_count;

  conductor_fresnel_reflectance_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cos_incident(in_cos_incident), .in_index_outside(in_index_outside),
    .in_index_inside(in_index_inside), .in_absorption(in_absorption),
    .out_valid(out_valid), .out_reflectance(out_reflectance)
  );

  cfr_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cos_incident(in_cos_incident), .in_index_outside(in_index_outside),
    .in_index_inside(in_index_inside), .in_absorption(in_absorption),
    .out_valid(out_valid), .out_reflectance(out_reflectance),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(input logic [16:0] cosv, input logic [15:0] o,
                              input logic [15:0] n, input logic [15:0] k, input bit allow_idle);
    if (allow_idle) begin
      while ($urandom_range(99) < 36) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_cos_incident <= cosv;
    in_index_outside <= o;
    in_index_inside <= n;
    in_absorption <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    request_count++;
  endtask

  function automatic logic [15:0] random_index();
    case ($urandom_range(3))
      0: return 16'($urandom_range(65535));
      1: return 16'($urandom_range(2048, 16384));
      2: return 16'($urandom_range(4095, 4097));
      default: return 16'($urandom_range(15));
    endcase
  endfunction

  function automatic logic [16:0] random_cos();
    case ($urandom_range(4))
      0: return 17'($urandom_range(131071));
      1: return 17'($urandom_range(32768, 32770));
      2: return 17'($urandom_range(3));
      default: return 17'($urandom_range(1, 32768));
    endcase
  endfunction

  initial begin
    logic [16:0] dir_cos[7];
    logic [15:0] dir_idx[5];
    rst_n = 1'b0;
    start = 1'b0;
    in_cos_incident = '0;
    in_index_outside = 16'h1000;
    in_index_inside = '0;
    in_absorption = '0;
    request_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir_cos = '{17'h10000, 17'h1ffff, 17'd0, 17'd1, 17'd23170, 17'd32768, 17'h0ffff};
    dir_idx = '{16'd0, 16'd1, 16'h1000, 16'h8000, 16'hffff};
    foreach (dir_cos[i]) send_request(dir_cos[i], 16'h1000, 16'h2000, 16'h3000, 1'b0);
    foreach (dir_idx[i]) send_request(17'd20000, dir_idx[i], dir_idx[(i + 2) % 5],
                                      dir_idx[(i + 4) % 5], 1'b0);
    send_request(17'd32768, 16'hffff, 16'hffff, 16'hffff, 1'b0);
    send_request(17'd1, 16'hffff, 16'd0, 16'd0, 1'b0);
    send_request(17'd30000, 16'h1000, 16'h1000, 16'd0, 1'b0);
    send_request(17'd16384, 16'h1000, 16'd0, 16'hffff, 1'b0);
    send_request(17'd32768, 16'd1, 16'd0, 16'd0, 1'b0);

    for (int i = 0; i < 800; i++) begin
      send_request(random_cos(), random_index(), random_index(), random_index(),
                   !(i >= 300 && i < 420));
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d requests and checked %0d reflectance results,", request_count,
             result_count);
    $display("covering non-positive, saturated and random cosines with extreme indices.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
